// File: hw/rtl/sssel_pkg.sv
package sssel_pkg;

    localparam int SAMPLE_DEPTH_DEF = 1024;
    localparam int MAX_PROCS_DEF    = 64;
    localparam int KEY_W            = 64;
    localparam int PROC_W           = 6;
    localparam int INDEX_W          = 32;
    localparam int SPP_W            = 11;
    localparam int NPROCS_W         = 7;
    localparam int REC_W            = KEY_W + PROC_W + INDEX_W;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_PROC = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PROCS        = 1'd1;

    localparam logic [KEY_W-1:0]   KEY_SENTINEL   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [PROC_W-1:0]  PROC_SENTINEL  = '1;
    localparam logic [INDEX_W-1:0] INDEX_SENTINEL = '1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PASS_INIT,
        ST_RD_A,
        ST_RD_B,
        ST_CMP,
        ST_COPY_B,
        ST_PASS_END,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_EMIT_OUT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_wr;     // write incoming sample at count
        logic clr_count;
        logic pass_init;   // reset pass pointers for current width
        logic rd_a;        // read head of run A
        logic rd_b;        // read head of run B
        logic take;        // write smaller head, advance that run
        logic copy_b;      // copy B-run remainder, advance
        logic pass_end;    // next pair, or on the last pair double width and swap banks
        logic emit_init;
        logic emit_rd;     // read store at splitter position
        logic emit_cap;    // capture result into output register
        logic emit_adv;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic sort_done;   // width covers all samples
        logic a_left;      // run A has elements left
        logic b_left;
        logic a_first;     // A head orders before or equal B head
        logic merge_done;  // current pair of runs finished
        logic pass_last;   // current pair is the last in the pass
        logic emit_last;
    } stat_t;

endpackage

// File: hw/rtl/sssel_if.sv
interface sssel_sample_if import sssel_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KEY_W-1:0]   sample_key;
    logic [PROC_W-1:0]  sample_proc;
    logic [INDEX_W-1:0] sample_index;
    logic               last_sample;
    modport source (output valid, sample_key, sample_proc, sample_index, last_sample,
                    input ready);
    modport sink   (input valid, sample_key, sample_proc, sample_index, last_sample,
                    output ready);
endinterface

interface sssel_splitter_if import sssel_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KEY_W-1:0]   splitter_key;
    logic [PROC_W-1:0]  splitter_proc;
    logic [INDEX_W-1:0] splitter_index;
    logic               is_sentinel;
    logic               last_splitter;
    modport source (output valid, splitter_key, splitter_proc, splitter_index,
                    is_sentinel, last_splitter, input ready);
    modport sink   (input valid, splitter_key, splitter_proc, splitter_index,
                    is_sentinel, last_splitter, output ready);
endinterface

interface sssel_cfg_if import sssel_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/sssel_ram.sv
module sssel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hw/rtl/sssel_datapath.sv
module sssel_datapath import sssel_pkg::*; #(
    parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
    parameter int MAX_PROCS    = MAX_PROCS_DEF,
    localparam int AW  = $clog2(SAMPLE_DEPTH),
    localparam int CW  = $clog2(SAMPLE_DEPTH + 1),
    localparam int WW  = CW + 1,
    localparam int PW  = $clog2(MAX_PROCS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output stat_t              stat,
    input  logic [KEY_W-1:0]   in_key,
    input  logic [PROC_W-1:0]  in_proc,
    input  logic [INDEX_W-1:0] in_index,
    input  logic [SPP_W-1:0]   spp,
    input  logic [NPROCS_W-1:0] nprocs,
    output logic [KEY_W-1:0]   out_key,
    output logic [PROC_W-1:0]  out_proc,
    output logic [INDEX_W-1:0] out_index,
    output logic               out_sent,
    output logic               out_last
);
    // Position products can reach spp * MAX_PROCS
    localparam int POSW = SPP_W + PW;

    logic [CW-1:0] count_reg;
    logic          bank_reg;       // bank holding current sorted runs
    logic [WW-1:0] width_reg;
    logic [WW:0]   base_reg;       // start of current pair
    logic [WW:0]   ia_reg, ib_reg; // offsets consumed in A and B
    logic [CW-1:0] wr_reg;
    logic [REC_W-1:0] a_reg, b_reg;
    logic [PW-1:0]    sel_reg;
    logic [POSW-1:0]  pos_reg;
    logic [PW-1:0]    n_eff;

    logic [WW:0] a_end, b_end, a_lim, b_lim;
    logic [WW:0] cnt_x;
    logic [AW-1:0] raddr, waddr;
    logic          we;
    logic [REC_W-1:0] wdata, rd0, rd1, rdata;
    logic [REC_W-1:0] b_cur;
    logic [KEY_W-1:0] ka, kb;
    logic             rd_a_d, rd_b_d;

    assign cnt_x = {{(WW+1-CW){1'b0}}, count_reg};
    assign a_end = base_reg + {1'b0, width_reg};
    assign b_end = a_end + {1'b0, width_reg};
    assign a_lim = (a_end < cnt_x) ? a_end : cnt_x;
    assign b_lim = (b_end < cnt_x) ? b_end : cnt_x;

    always_comb
    begin
        if (nprocs == '0)
            n_eff = PW'(1);
        else if ({{(32-NPROCS_W){1'b0}}, nprocs} > MAX_PROCS)
            n_eff = PW'(MAX_PROCS);
        else
            n_eff = PW'(nprocs);
    end

    logic [WW:0] a_pos, b_pos;
    assign a_pos = base_reg + ia_reg;
    assign b_pos = a_end + ib_reg;

    assign stat.full       = (count_reg == CW'(SAMPLE_DEPTH));
    assign stat.sort_done  = ({1'b0, width_reg} >= cnt_x);
    assign stat.a_left     = (a_pos < a_lim);
    assign stat.b_left     = (b_pos < b_lim);
    assign stat.merge_done = !stat.a_left && !stat.b_left;
    assign stat.pass_last  = (b_end >= cnt_x);
    assign stat.emit_last  = ({{(32-PW){1'b0}}, sel_reg} + 1 >= {{(32-PW){1'b0}}, n_eff});

    // B head arrives from the bank in the cycle after its read
    assign b_cur = rd_b_d ? rdata : b_reg;

    // Signed key order: flip sign bit, then unsigned compare of whole record
    assign ka = a_reg[REC_W-1 -: KEY_W] ^ {1'b1, {(KEY_W-1){1'b0}}};
    assign kb = b_cur[REC_W-1 -: KEY_W] ^ {1'b1, {(KEY_W-1){1'b0}}};
    assign stat.a_first = {ka, a_reg[PROC_W+INDEX_W-1:0]}
                       <= {kb, b_cur[PROC_W+INDEX_W-1:0]};

    // Read address and write port selection
    always_comb
    begin
        raddr = AW'(a_pos);
        we    = 1'b0;
        waddr = AW'(wr_reg);
        wdata = a_reg;
        if (cmd.rd_b)
            raddr = AW'(b_pos);
        if (cmd.emit_rd)
            raddr = AW'(pos_reg);
        if (cmd.load_wr)
        begin
            we    = !stat.full;
            waddr = AW'(count_reg);
            wdata = {in_key, in_proc, in_index};
        end
        else if (cmd.take || cmd.copy_b)
        begin
            we    = 1'b1;
            wdata = (cmd.copy_b || !stat.a_left ||
                     (stat.b_left && !stat.a_first)) ? b_cur : a_reg;
            if (cmd.copy_b)
                wdata = b_cur;
            else if (!stat.b_left || (stat.a_left && stat.a_first))
                wdata = a_reg;
        end
    end

    // Two banks: load goes to bank 0; merge reads bank_reg, writes the other
    logic we0, we1;
    assign we0 = we && (cmd.load_wr ? 1'b1 : bank_reg);
    assign we1 = we && !cmd.load_wr && !bank_reg;

    sssel_ram #(.WIDTH(REC_W), .DEPTH(SAMPLE_DEPTH)) u_bank0 (
        .clk(clk), .we(we0), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd0));
    sssel_ram #(.WIDTH(REC_W), .DEPTH(SAMPLE_DEPTH)) u_bank1 (
        .clk(clk), .we(we1), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd1));

    assign rdata = bank_reg ? rd1 : rd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            bank_reg  <= 1'b0;
            width_reg <= WW'(1);
            base_reg  <= '0;
            ia_reg    <= '0;
            ib_reg    <= '0;
            wr_reg    <= '0;
            sel_reg   <= '0;
            pos_reg   <= '0;
            rd_a_d    <= 1'b0;
            rd_b_d    <= 1'b0;
        end
        else
        begin
            rd_a_d <= cmd.rd_a;
            rd_b_d <= cmd.rd_b;
            if (cmd.load_wr && !stat.full)
                count_reg <= count_reg + CW'(1);
            if (cmd.clr_count)
            begin
                count_reg <= '0;
                bank_reg  <= 1'b0;
                width_reg <= WW'(1);
            end
            if (cmd.pass_init)
            begin
                base_reg <= '0;
                ia_reg   <= '0;
                ib_reg   <= '0;
                wr_reg   <= '0;
            end
            if (cmd.take)
            begin
                wr_reg <= wr_reg + CW'(1);
                if (!stat.b_left || (stat.a_left && stat.a_first))
                    ia_reg <= ia_reg + (WW+1)'(1);
                else
                    ib_reg <= ib_reg + (WW+1)'(1);
            end
            if (cmd.copy_b)
            begin
                wr_reg <= wr_reg + CW'(1);
                ib_reg <= ib_reg + (WW+1)'(1);
            end
            if (cmd.pass_end)
            begin
                if (stat.pass_last)
                begin
                    width_reg <= width_reg << 1;
                    bank_reg  <= !bank_reg;
                end
                else
                begin
                    base_reg <= b_end;
                    ia_reg   <= '0;
                    ib_reg   <= '0;
                end
            end
            if (cmd.emit_init)
            begin
                sel_reg <= '0;
                pos_reg <= POSW'(spp);
            end
            if (cmd.emit_adv)
            begin
                sel_reg <= sel_reg + PW'(1);
                pos_reg <= pos_reg + POSW'(spp);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_a_d)
            a_reg <= rdata;
        if (rd_b_d)
            b_reg <= rdata;
        if (cmd.emit_cap)
        begin
            out_last <= stat.emit_last;
            if (!stat.emit_last && {{(32-POSW){1'b0}}, pos_reg} <
                {{(32-CW){1'b0}}, count_reg})
            begin
                {out_key, out_proc, out_index} <= rdata;
                out_sent <= 1'b0;
            end
            else
            begin
                out_key   <= KEY_SENTINEL;
                out_proc  <= PROC_SENTINEL;
                out_index <= INDEX_SENTINEL;
                out_sent  <= 1'b1;
            end
        end
    end
endmodule

// File: hw/rtl/sssel_ctrl.sv
module sssel_ctrl import sssel_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output cmd_t  cmd,
    input  logic  in_valid,
    input  logic  in_last,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_LOAD;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_wr = 1'b1;
                    if (in_last)
                        state_next = ST_PASS_INIT;
                end
            end
            ST_PASS_INIT:
            begin
                if (stat.sort_done)
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = ST_EMIT_RD;
                end
                else
                begin
                    cmd.pass_init = 1'b1;
                    state_next    = ST_RD_A;
                end
            end
            ST_RD_A:
            begin
                if (stat.merge_done)
                    state_next = ST_PASS_END;
                else if (stat.a_left)
                begin
                    cmd.rd_a   = 1'b1;
                    state_next = ST_RD_B;
                end
                else
                begin
                    cmd.rd_b   = 1'b1;
                    state_next = ST_COPY_B;
                end
            end
            ST_RD_B:
            begin
                cmd.rd_b   = stat.b_left;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.take   = 1'b1;
                state_next = ST_RD_A;
            end
            ST_COPY_B:
            begin
                cmd.copy_b = 1'b1;
                state_next = ST_RD_A;
            end
            ST_PASS_END:
            begin
                cmd.pass_end = 1'b1;
                state_next   = stat.pass_last ? ST_PASS_INIT : ST_RD_A;
            end
            ST_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                cmd.emit_cap = 1'b1;
                state_next   = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (stat.emit_last)
                    begin
                        cmd.clr_count = 1'b1;
                        state_next    = ST_LOAD;
                    end
                    else
                    begin
                        cmd.emit_adv = 1'b1;
                        state_next   = ST_EMIT_RD;
                    end
                end
            end
            default:
                state_next = ST_LOAD;
        endcase
    end
endmodule

// File: hw/rtl/sample_sort_splitter_select_top.sv
// Sample sort splitter selection. Samples are written into a two-bank record
// store until one marked last_sample; samples beyond SAMPLE_DEPTH are dropped.
// The store is then sorted by a bottom-up merge sort (key signed, then process,
// then index), ceil(log2(N)) passes, one per doubling of run width; the
// single-read-port bank supplies one run head per cycle. Then num_procs
// splitters are emitted, each read from the store, captured and offered until
// the sink takes it; the final one and any past the loaded count are the max
// sentinel. No input is taken during sort and emit. Configure only when idle.
module sample_sort_splitter_select_top import sssel_pkg::*; #(
    parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
    parameter int MAX_PROCS    = MAX_PROCS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    sssel_sample_if.sink     samples,
    sssel_splitter_if.source splitters,
    sssel_cfg_if.sink        cfg
);
    cmd_t  cmd;
    stat_t stat;
    logic [SPP_W-1:0]    spp_reg;
    logic [NPROCS_W-1:0] nprocs_reg;

    // Accept configuration writes at any time
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spp_reg    <= SPP_W'(1);
            nprocs_reg <= NPROCS_W'(1);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_SAMPLES_PER_PROC: spp_reg    <= cfg.data[SPP_W-1:0];
                CFG_NUM_PROCS:        nprocs_reg <= cfg.data[NPROCS_W-1:0];
                default: ;
            endcase
        end
    end

    sssel_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .stat(stat), .cmd(cmd),
        .in_valid(samples.valid), .in_last(samples.last_sample),
        .in_ready(samples.ready),
        .out_valid(splitters.valid), .out_ready(splitters.ready)
    );

    sssel_datapath #(.SAMPLE_DEPTH(SAMPLE_DEPTH), .MAX_PROCS(MAX_PROCS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_key(samples.sample_key), .in_proc(samples.sample_proc),
        .in_index(samples.sample_index),
        .spp(spp_reg), .nprocs(nprocs_reg),
        .out_key(splitters.splitter_key), .out_proc(splitters.splitter_proc),
        .out_index(splitters.splitter_index), .out_sent(splitters.is_sentinel),
        .out_last(splitters.last_splitter)
    );
endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import sssel_pkg::*;

    localparam int STORE_DEPTH = SAMPLE_DEPTH_DEF;
    localparam int SPLIT_MAX   = MAX_PROCS_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 60;
    localparam int RANDOM_ITEMS = 360;

    // Idle patterns on the two channels
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef enum int {
        ROW_CFG,
        ROW_SAMPLE
    } row_kind_t;

    typedef struct {
        logic signed [KEY_W-1:0] key;
        logic [PROC_W-1:0]       proc;
        logic [INDEX_W-1:0]      idx;
        logic                    last;
    } sample_t;

    typedef struct {
        logic signed [KEY_W-1:0] key;
        logic [PROC_W-1:0]       proc;
        logic [INDEX_W-1:0]      idx;
        logic                    sentinel;
        logic                    last;
    } splitter_t;

    // One row of the directed table. A typed row carries its own expectation:
    // with a single splitter per burst the only result is the sentinel.
    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        sample_t               smp;
        bit                    typed;
    } row_t;

    logic clk;
    logic rst_n;

    sssel_sample_if   samples ();
    sssel_splitter_if splitters ();
    sssel_cfg_if      cfg ();

    sample_sort_splitter_select_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples.sink),
        .splitters (splitters.source),
        .cfg       (cfg.sink)
    );

    // Shadow of the block: loaded records, settings, and splitters still owed
    sample_t    held_samples[$];
    splitter_t  pending_splitters[$];
    int         spacing;
    int         proc_count;
    row_t       directed_rows[$];

    idle_mode_t idle_mode;
    int         mismatches;
    int         cycles;
    int         hold_left;
    bit         hold_armed;
    bit         stim_done;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Keep every input known from time zero
    initial
    begin
        rst_n                = 1'b0;
        samples.valid        = 1'b0;
        samples.sample_key   = '0;
        samples.sample_proc  = '0;
        samples.sample_index = '0;
        samples.last_sample  = 1'b0;
        splitters.ready      = 1'b0;
        cfg.valid            = 1'b0;
        cfg.index            = '0;
        cfg.data             = '0;
    end

    // Record order: signed key, then process, then index
    function automatic bit orders_first(sample_t a, sample_t b);
        if (a.key != b.key)
            return a.key < b.key;
        if (a.proc != b.proc)
            return a.proc < b.proc;
        return a.idx < b.idx;
    endfunction

    function automatic splitter_t sentinel_splitter(bit last);
        splitter_t s;
        s.key      = KEY_SENTINEL;
        s.proc     = PROC_SENTINEL;
        s.idx      = INDEX_SENTINEL;
        s.sentinel = 1'b1;
        s.last     = last;
        return s;
    endfunction

    // Sort the held records and queue the burst of splitters they select
    function automatic void select_splitters(bit typed);
        sample_t   cur;
        splitter_t s;
        int        j;
        int        n;
        longint    pos;
        for (int i = 1; i < held_samples.size(); i++)
        begin
            cur = held_samples[i];
            j   = i;
            while (j > 0 && orders_first(cur, held_samples[j-1]))
            begin
                held_samples[j] = held_samples[j-1];
                j--;
            end
            held_samples[j] = cur;
        end
        n = proc_count;
        if (n == 0)
            n = 1;
        if (n > SPLIT_MAX)
            n = SPLIT_MAX;
        if (typed)
            // directed rows: a lone sentinel marks the end of the burst
            pending_splitters.push_back(sentinel_splitter(1'b1));
        else
            for (int i = 0; i < n; i++)
            begin
                pos = longint'(spacing) * (i + 1);
                if (i + 1 < n && pos < held_samples.size())
                begin
                    s.key      = held_samples[pos].key;
                    s.proc     = held_samples[pos].proc;
                    s.idx      = held_samples[pos].idx;
                    s.sentinel = 1'b0;
                    s.last     = 1'b0;
                end
                else
                    s = sentinel_splitter(i + 1 == n);
                pending_splitters.push_back(s);
            end
        held_samples.delete();
    endfunction

    function automatic void take_sample(sample_t smp, bit typed);
        // drop once the store is full; a last mark still fires the burst
        if (held_samples.size() < STORE_DEPTH)
            held_samples.push_back(smp);
        if (smp.last)
            select_splitters(typed);
    endfunction

    function automatic bit roll_idle();
        case (idle_mode)
            IDLE_SENDER, IDLE_RECEIVER: return $urandom_range(99) < 51;
            IDLE_BOTH:                  return $urandom_range(99) < 16;
            default:                    return 1'b0;
        endcase
    endfunction

    // Offer one request; data changes only at the falling edge
    task automatic send_sample(sample_t smp, bit typed);
        @(negedge clk);
        while ((idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) && roll_idle())
        begin
            samples.valid <= 1'b0;
            @(negedge clk);
        end
        samples.valid        <= 1'b1;
        samples.sample_key   <= smp.key;
        samples.sample_proc  <= smp.proc;
        samples.sample_index <= smp.idx;
        samples.last_sample  <= smp.last;
        do
            @(posedge clk);
        while (!samples.ready);
        take_sample(smp, typed);
    endtask

    // Settle the block before touching a register: drain, then allow the tail
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        samples.valid <= 1'b0;
        while (pending_splitters.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do
            @(posedge clk);
        while (!cfg.ready);
        if (idx == CFG_SAMPLES_PER_PROC)
            spacing = int'(data[SPP_W-1:0]);
        else
            proc_count = int'(data[NPROCS_W-1:0]);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Scatter junk over the unused upper bits of a register write
    function automatic logic [CFG_DATA_W-1:0] reg_word(int value, int width);
        logic [CFG_DATA_W-1:0] w;
        w = {$urandom, $urandom};
        for (int b = 0; b < width; b++)
            w[b] = value[b];
        return w;
    endfunction

    task automatic set_config(int spp, int np);
        write_reg(CFG_SAMPLES_PER_PROC, reg_word(spp, SPP_W));
        write_reg(CFG_NUM_PROCS, reg_word(np, NPROCS_W));
    endtask

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, int value);
        row_t r;
        r.kind     = ROW_CFG;
        r.reg_idx  = idx;
        r.reg_data = reg_word(value, (idx == CFG_NUM_PROCS) ? NPROCS_W : SPP_W);
        r.smp      = '{default: '0};
        r.typed    = 1'b0;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_smp(logic signed [KEY_W-1:0] key, logic [PROC_W-1:0] proc,
                                    logic [INDEX_W-1:0] idx, bit last, bit typed);
        row_t r;
        r.kind     = ROW_SAMPLE;
        r.reg_idx  = '0;
        r.reg_data = '0;
        r.smp      = '{key, proc, idx, last};
        r.typed    = typed;
        directed_rows.push_back(r);
    endfunction

    // Mix of key shapes: ties from a tiny pool, the extremes, and full range
    function automatic sample_t random_sample(bit last);
        sample_t s;
        case ($urandom_range(7))
            0, 1:    s.key = $signed(64'($urandom_range(4))) - 2;
            2:       s.key = $urandom_range(1) ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            default: s.key = {$urandom, $urandom};
        endcase
        s.proc = $urandom_range(3) == 0 ? PROC_W'($urandom_range(1)) : PROC_W'($urandom);
        s.idx  = $urandom_range(3) == 0 ? INDEX_W'($urandom_range(2)) : $urandom;
        s.last = last;
        return s;
    endfunction

    // Receiver: random stalls, or a long hold-off while the sender keeps going
    always @(negedge clk)
    begin
        if (!rst_n || hold_left > 0)
            splitters.ready <= 1'b0;
        else if (idle_mode == IDLE_RECEIVER || idle_mode == IDLE_BOTH)
            splitters.ready <= !roll_idle();
        else
            splitters.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (hold_armed && splitters.valid)
        begin
            hold_armed <= 1'b0;
            hold_left  <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Compare each accepted splitter with the oldest one owed
    always @(posedge clk)
    begin
        splitter_t want;
        if (rst_n && splitters.valid && splitters.ready)
        begin
            if (pending_splitters.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected splitter key=%0d proc=%0d", splitters.splitter_key,
                             splitters.splitter_proc);
            end
            else
            begin
                want = pending_splitters.pop_front();
                if (splitters.splitter_key !== want.key ||
                    splitters.splitter_proc !== want.proc ||
                    splitters.splitter_index !== want.idx ||
                    splitters.is_sentinel !== want.sentinel ||
                    splitters.last_splitter !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("splitter mismatch exp k=%0d p=%0d i=%0h s=%0b l=%0b got k=%0d p=%0d i=%0h s=%0b l=%0b",
                                 want.key, want.proc, want.idx, want.sentinel, want.last,
                                 $signed(splitters.splitter_key), splitters.splitter_proc,
                                 splitters.splitter_index, splitters.is_sentinel,
                                 splitters.last_splitter);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int sent;
        int load_len;
        int settings[8][2];
        settings = '{'{1, 64}, '{0, 5}, '{2047, 127}, '{3, 0},
                     '{1024, 64}, '{5, 9}, '{2, 20}, '{7, 3}};
        spacing    = 1;
        proc_count = 1;
        mismatches = 0;
        cycles     = 0;
        hold_left  = 0;
        hold_armed = 1'b0;
        stim_done  = 1'b0;
        idle_mode  = IDLE_NONE;

        // Directed table. Under the reset settings each burst is one sentinel.
        add_smp({1'b1, 63'd0}, '0, '0, 1'b1, 1'b1);             // lone sample, min key
        add_smp({1'b1, 63'd0}, '0, '0, 1'b0, 1'b0);
        add_smp({1'b0, {63{1'b1}}}, '1, '1, 1'b0, 1'b0);
        add_smp(64'sd0, 6'd1, 32'd1, 1'b1, 1'b1);
        // ties on key and process, resolved by index
        add_cfg(CFG_NUM_PROCS, 4);
        add_smp(64'sd5, 6'd3, 32'd9, 1'b0, 1'b0);
        add_smp(64'sd5, 6'd3, 32'd2, 1'b0, 1'b0);
        add_smp(64'sd5, 6'd1, 32'd7, 1'b0, 1'b0);
        add_smp(-64'sd1, 6'd0, 32'd0, 1'b0, 1'b0);
        add_smp({1'b1, 63'd0}, 6'd63, 32'd5, 1'b0, 1'b0);
        add_smp({1'b0, {63{1'b1}}}, '1, '1, 1'b1, 1'b0);
        // zero spacing picks position zero for every splitter but the last
        add_cfg(CFG_SAMPLES_PER_PROC, 0);
        add_smp(64'sd9, 6'd2, 32'd4, 1'b0, 1'b0);
        add_smp(-64'sd9, 6'd2, 32'd4, 1'b0, 1'b0);
        add_smp(64'sd9, 6'd1, 32'd4, 1'b1, 1'b0);
        // zero processes acts as one
        add_cfg(CFG_NUM_PROCS, 0);
        add_smp(64'sd3, 6'd3, 32'd3, 1'b1, 1'b1);
        // saturated process count, most positions past the load
        add_cfg(CFG_SAMPLES_PER_PROC, 1);
        add_cfg(CFG_NUM_PROCS, 127);
        add_smp(64'sd2, 6'd0, 32'hFFFF_FFFF, 1'b0, 1'b0);
        add_smp(64'sd1, 6'd63, 32'd0, 1'b1, 1'b0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
            else
                send_sample(directed_rows[i].smp, directed_rows[i].typed);
        end

        // Random loads, walking settings and idle patterns; the pause before
        // each register write lets every owed splitter drain first
        sent = 0;
        for (int ph = 0; sent < RANDOM_ITEMS; ph++)
        begin
            set_config(settings[ph % 8][0], settings[ph % 8][1]);
            idle_mode = idle_mode_t'(ph % 4);
            if (ph == 2)
                hold_armed = 1'b1;
            for (int ld = 0; ld < 3; ld++)
            begin
                load_len = $urandom_range(3) == 0 ? $urandom_range(1, 3) : $urandom_range(4, 40);
                for (int i = 0; i < load_len; i++)
                    send_sample(random_sample(i == load_len - 1), 1'b0);
                sent += load_len;
            end
        end

        @(negedge clk);
        samples.valid <= 1'b0;
        while (pending_splitters.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && pending_splitters.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
